### sv/mctft_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-channel tick flag timer core.
// Holds command codes, item structs and per-channel word layout.
// No dependencies.
package mctft_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 8;
    localparam int unsigned PERIOD_W         = 32;
    localparam int unsigned PEND_W           = 8;
    localparam int unsigned CHAN_W           = 3;

    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_REGISTER = 3'd1,
        OP_ENABLE   = 3'd2,
        OP_DISABLE  = 3'd3,
        OP_SET_PER  = 3'd4,
        OP_CLEAR    = 3'd5,
        OP_DECR     = 3'd6,
        OP_READ     = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [CHAN_W-1:0]     channel;
        logic [PERIOD_W-1:0]   period;
    } cmd_item_t;

    typedef struct packed {
        logic                  status;
        logic [CHAN_W-1:0]     assigned_channel;
        logic [PEND_W-1:0]     pending_events;
        logic                  channel_enabled;
    } rsp_item_t;

    // One channel's state as held in the channel memory
    typedef struct packed {
        logic [PERIOD_W-1:0]   period;
        logic [PERIOD_W-1:0]   counter;
        logic [PEND_W-1:0]     pending;
        logic                  enabled;
    } chan_word_t;

endpackage

### sv/multi_channel_tick_flag_timer_core.sv
`timescale 1ns / 1ps
// Multi-channel periodic tick flag timer: top level and sequencer.
// Channel state lives in one memory, walked by a shared update unit.
// Depends on mctft_pkg.
//
//  port group   dir  handshake             payload
//  cmd          in   cmd_valid/cmd_ready   cmd_item_t (opcode, channel, period)
//  rsp          out  rsp_valid/rsp_ready   rsp_item_t (status, channel, pending, enable)
//
// A tick walks every channel in turn: each channel is read, then updated and
// written back while the next one is read, and the result follows the last.
// Any other command steps through accept/read, modify/write, result.
// A refused register or a non-tick command on an out-of-range channel skips the memory.
// Reset clears the per-channel valid bits; an invalid entry reads as zero.
// cmd_ready is low from acceptance until the result item has been taken.
module multi_channel_tick_flag_timer_core
    import mctft_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_item_t  cmd,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_item_t  rsp
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(NUM_CHANNELS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_CHANNELS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_MOD  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [CHAN_W-1:0]   ch_reg, ch_next;
    logic                ch_ok_reg, ch_ok_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    rsp_item_t           rsp_reg, rsp_next;

    chan_word_t          chan_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;
    chan_word_t          rd_word_reg;
    logic                rd_vld_reg;

    logic                mem_re, mem_we;
    logic [IDX_W-1:0]    mem_ra, mem_wa;
    chan_word_t          mem_wd;

    chan_word_t          cur_word, new_word;
    logic                cmd_ch_ok;

    function automatic chan_word_t tick_word(input chan_word_t w);
        chan_word_t          r;
        logic [PERIOD_W-1:0] c;
        r = w;
        c = w.counter + PERIOD_W'(1);
        if (w.enabled)
        begin
            r.counter = c;
            if (c == w.period)
            begin
                r.counter = '0;
                if (w.pending != PEND_MAX)
                    r.pending = w.pending + PEND_W'(1);
            end
        end
        return r;
    endfunction

    function automatic chan_word_t cmd_word(input chan_word_t w, input opcode_t op,
                                            input logic [PERIOD_W-1:0] per);
        chan_word_t r;
        r = w;
        case (op)
            OP_REGISTER, OP_SET_PER:
            begin
                r.period  = per;
                r.counter = '0;
                r.pending = '0;
                r.enabled = (per != '0);
            end
            OP_ENABLE:  r.enabled = 1'b1;
            OP_DISABLE: r.enabled = 1'b0;
            OP_CLEAR:   r.pending = '0;
            OP_DECR:
            begin
                if (w.pending != '0)
                    r.pending = w.pending - PEND_W'(1);
            end
            default:    r = w;
        endcase
        return r;
    endfunction

    assign cur_word  = rd_vld_reg ? rd_word_reg : '0;
    assign new_word  = (op_reg == OP_TICK) ? tick_word(cur_word)
                                           : cmd_word(cur_word, op_reg, per_reg);
    assign cmd_ch_ok = (32'(cmd.channel) < NUM_CHANNELS);

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        ch_ok_next = ch_ok_reg;
        per_next   = per_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        rsp_next   = rsp_reg;
        mem_re     = 1'b0;
        mem_ra     = idx_reg;
        mem_we     = 1'b0;
        mem_wa     = idx_reg;
        mem_wd     = new_word;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd.opcode;
                    ch_next    = cmd.channel;
                    ch_ok_next = cmd_ch_ok;
                    per_next   = cmd.period;
                    rsp_next   = '{status: 1'b0, assigned_channel: cmd.channel,
                                   pending_events: '0, channel_enabled: 1'b0};
                    case (cmd.opcode)
                        OP_TICK:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = '0;
                            idx_next   = '0;
                            state_next = S_WALK;
                        end
                        OP_REGISTER:
                        begin
                            if (used_reg == USED_FULL)
                            begin
                                rsp_next.status           = 1'b1;
                                rsp_next.assigned_channel = '0;
                                state_next                = S_OUT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = IDX_W'(used_reg);
                                idx_next   = IDX_W'(used_reg);
                                used_next  = used_reg + CNT_W'(1);
                                rsp_next.assigned_channel = CHAN_W'(used_reg);
                                state_next = S_MOD;
                            end
                        end
                        default:
                        begin
                            if (cmd_ch_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = IDX_W'(cmd.channel);
                                idx_next   = IDX_W'(cmd.channel);
                                state_next = S_MOD;
                            end
                            else
                                state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                mem_we = 1'b1;
                if (ch_ok_reg && (idx_reg == IDX_W'(ch_reg)))
                begin
                    rsp_next.pending_events  = new_word.pending;
                    rsp_next.channel_enabled = new_word.enabled;
                end
                if (idx_reg == IDX_LAST)
                    state_next = S_OUT;
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_MOD:
            begin
                mem_we                   = 1'b1;
                rsp_next.pending_events  = new_word.pending;
                rsp_next.channel_enabled = new_word.enabled;
                state_next               = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (mem_we)
                vld_reg[mem_wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ch_reg    <= ch_next;
        ch_ok_reg <= ch_ok_next;
        per_reg   <= per_next;
        idx_reg   <= idx_next;
        rsp_reg   <= rsp_next;
    end

    // channel memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            chan_mem[mem_wa] <= mem_wd;
        if (mem_re)
        begin
            rd_word_reg <= chan_mem[mem_ra];
            rd_vld_reg  <= vld_reg[mem_ra];
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_FULL)
        else $error("channel allocation count beyond table size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && (cmd.opcode == OP_REGISTER) && (used_reg != USED_FULL))
        |=> (used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("register did not take a channel");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |->
        ((rsp.pending_events == '0) && !rsp.channel_enabled && (rsp.assigned_channel == '0)))
        else $error("refused register reports channel state");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (32'(idx_reg) < NUM_CHANNELS))
        else $error("tick walk index out of range");

endmodule

### sim/multi_channel_tick_flag_timer_core_tb.sv
`timescale 1ns / 1ps
// Testbench for multi_channel_tick_flag_timer_core: a directed table, then random
// and saturation traffic, checked against typed rows or a shadow timer bank.
// Depends on mctft_pkg and the core RTL.
module multi_channel_tick_flag_timer_core_tb;
    import mctft_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        cmd_item_t c;
        bit        typed;
        rsp_item_t r;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    logic [PERIOD_W-1:0] per_tab  [NUM_CHANNELS_DEF];
    logic [PERIOD_W-1:0] tick_cnt [NUM_CHANNELS_DEF];
    logic [PEND_W-1:0]   pend_cnt [NUM_CHANNELS_DEF];
    logic                chan_en  [NUM_CHANNELS_DEF];
    int unsigned         used_cnt;

    rsp_item_t replies_due [$];
    plan_row_t plan [$];
    int        errors = 0;
    int        cycle_cnt = 0;
    int        burst_left = 0;

    multi_channel_tick_flag_timer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("** multi_channel_tick_flag_timer_core: FAILED **");
            $finish;
        end
    end

    function automatic void load_chan(int ch, logic [PERIOD_W-1:0] per);
        per_tab[ch]  = per;
        tick_cnt[ch] = '0;
        pend_cnt[ch] = '0;
        chan_en[ch]  = (per != '0);
    endfunction

    function automatic rsp_item_t timer_step(cmd_item_t c);
        rsp_item_t r;
        int        slot;
        bit        hit;
        r    = '0;
        slot = c.channel;
        hit  = (c.channel < NUM_CHANNELS_DEF);
        case (c.opcode)
            OP_REGISTER:
            begin
                if (used_cnt < NUM_CHANNELS_DEF)
                begin
                    slot = used_cnt;
                    load_chan(slot, c.period);
                    used_cnt++;
                    hit = 1'b1;
                end
                else
                begin
                    r.status = 1'b1;
                    slot     = 0;
                    hit      = 1'b0;
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < NUM_CHANNELS_DEF; i++)
                begin
                    if (chan_en[i])
                    begin
                        tick_cnt[i] = tick_cnt[i] + 1'b1;
                        if (tick_cnt[i] == per_tab[i])
                        begin
                            if (pend_cnt[i] != PEND_MAX)
                                pend_cnt[i] = pend_cnt[i] + 1'b1;
                            tick_cnt[i] = '0;
                        end
                    end
                end
            end
            OP_ENABLE:  if (hit) chan_en[slot] = 1'b1;
            OP_DISABLE: if (hit) chan_en[slot] = 1'b0;
            OP_SET_PER: if (hit) load_chan(slot, c.period);
            OP_CLEAR:   if (hit) pend_cnt[slot] = '0;
            OP_DECR:    if (hit && pend_cnt[slot] != '0) pend_cnt[slot] = pend_cnt[slot] - 1'b1;
            default:    ;
        endcase
        r.assigned_channel = slot[CHAN_W-1:0];
        if (hit)
        begin
            r.pending_events  = pend_cnt[slot];
            r.channel_enabled = chan_en[slot];
        end
        return r;
    endfunction

    function automatic cmd_item_t make_cmd(opcode_t op, int ch, logic [PERIOD_W-1:0] per);
        cmd_item_t c;
        c.opcode  = op;
        c.channel = ch[CHAN_W-1:0];
        c.period  = per;
        return c;
    endfunction

    function automatic void add_row(opcode_t op, int ch, logic [PERIOD_W-1:0] per, bit typed,
                                    bit st, int ach, int pend, bit en);
        plan_row_t row;
        row.c                  = make_cmd(op, ch, per);
        row.typed              = typed;
        row.r.status           = st;
        row.r.assigned_channel = ach[CHAN_W-1:0];
        row.r.pending_events   = pend[PEND_W-1:0];
        row.r.channel_enabled  = en;
        plan.push_back(row);
    endfunction

    function automatic logic [PERIOD_W-1:0] rand_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return '1;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // payload and valid change only at edges; prediction made at acceptance
    task automatic send(cmd_item_t c, bit typed, rsp_item_t r);
        rsp_item_t pred;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        pred = timer_step(c);
        replies_due.push_back(typed ? r : pred);
    endtask

    task automatic drain();
        cmd_valid  <= 1'b0;
        burst_left = 0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply item with nothing due: %h", rsp);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("assigned_channel", want.assigned_channel, rsp.assigned_channel);
                check_field("pending_events", want.pending_events, rsp.pending_events);
                check_field("channel_enabled", want.channel_enabled, rsp.channel_enabled);
            end
        end
    end

    initial
    begin
        int mode;
        int span;
        span = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(8, 60);
            end
            span--;
            case (mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= 1'($urandom_range(0, 1));
                default: rsp_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial
    begin
        cmd_item_t c;
        int        r;
        int        ch;
        opcode_t   op;
        for (int i = 0; i < NUM_CHANNELS_DEF; i++)
            load_chan(i, '0);
        used_cnt = 0;

        add_row(OP_READ,     7, 0,             1, 0, 7, 0, 0);
        add_row(OP_TICK,     3, 0,             1, 0, 3, 0, 0);
        add_row(OP_REGISTER, 5, 0,             1, 0, 0, 0, 0);
        add_row(OP_REGISTER, 0, 1,             1, 0, 1, 0, 1);
        add_row(OP_REGISTER, 0, 32'hFFFF_FFFF, 1, 0, 2, 0, 1);
        add_row(OP_REGISTER, 0, 2,             1, 0, 3, 0, 1);
        add_row(OP_TICK,     1, 0,             1, 0, 1, 1, 1);
        add_row(OP_TICK,     3, 0,             0, 0, 0, 0, 0);
        add_row(OP_DECR,     1, 0,             0, 0, 0, 0, 0);
        add_row(OP_DECR,     1, 0,             1, 0, 1, 0, 1);
        add_row(OP_DECR,     1, 0,             1, 0, 1, 0, 1);
        add_row(OP_ENABLE,   0, 0,             1, 0, 0, 0, 1);
        add_row(OP_TICK,     0, 0,             0, 0, 0, 0, 0);
        add_row(OP_DISABLE,  2, 0,             1, 0, 2, 0, 0);
        add_row(OP_SET_PER,  5, 3,             1, 0, 5, 0, 1);
        add_row(OP_CLEAR,    3, 0,             1, 0, 3, 0, 1);
        add_row(OP_REGISTER, 0, 1,             1, 0, 4, 0, 1);
        add_row(OP_REGISTER, 0, 0,             1, 0, 5, 0, 0);
        add_row(OP_REGISTER, 7, 32'h8000_0001, 1, 0, 6, 0, 1);
        add_row(OP_REGISTER, 0, 3,             1, 0, 7, 0, 1);
        add_row(OP_REGISTER, 3, 32'h5555_AAAA, 1, 1, 0, 0, 0);
        add_row(OP_READ,     4, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(OP_SET_PER,  6, 0,             1, 0, 6, 0, 0);
        add_row(OP_TICK,     7, 0,             0, 0, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send(plan[i].c, plan[i].typed, plan[i].r);

        for (int n = 0; n < 250; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)      op = OP_TICK;
            else if (r < 48) op = OP_READ;
            else if (r < 58) op = OP_ENABLE;
            else if (r < 64) op = OP_DISABLE;
            else if (r < 76) op = OP_SET_PER;
            else if (r < 81) op = OP_CLEAR;
            else if (r < 95) op = OP_DECR;
            else             op = OP_REGISTER;
            c = make_cmd(op, $urandom_range(0, NUM_CHANNELS_DEF - 1), rand_period());
            send(c, 0, '0);
        end

        // hold off until the bank is quiet, then drive one channel into saturation
        drain();
        ch = $urandom_range(0, NUM_CHANNELS_DEF - 1);
        send(make_cmd(OP_SET_PER, ch, 1), 0, '0);
        send(make_cmd(OP_SET_PER, (ch + 1) % NUM_CHANNELS_DEF, 2), 0, '0);
        for (int n = 0; n < 275; n++)
        begin
            if ($urandom_range(0, 15) == 0)
                c = make_cmd(OP_READ, $urandom_range(0, NUM_CHANNELS_DEF - 1), $urandom);
            else
                c = make_cmd(OP_TICK, ($urandom_range(0, 3) == 0) ?
                             $urandom_range(0, NUM_CHANNELS_DEF - 1) : ch, $urandom);
            send(c, 0, '0);
        end
        send(make_cmd(OP_DECR, ch, 0), 0, '0);
        send(make_cmd(OP_TICK, ch, 0), 0, '0);
        send(make_cmd(OP_CLEAR, ch, 0), 0, '0);
        send(make_cmd(OP_READ, ch, 0), 0, '0);

        drain();
        repeat (NUM_CHANNELS_DEF + 8) @(posedge clk);
        if (errors == 0 && replies_due.size() == 0)
            $display("** multi_channel_tick_flag_timer_core: PASSED **");
        else
            $display("** multi_channel_tick_flag_timer_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
sv/mctft_pkg.sv
sv/multi_channel_tick_flag_timer_core.sv
sim/multi_channel_tick_flag_timer_core_tb.sv
